FILE: sv/masked_byte_pattern_scanner_top_defines.svh
// Assertion macros shared by the masked byte pattern scanner RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MBPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mbps_pkg.sv
// Package for the masked byte pattern scanner: payload structs, register
// indexes, status codes and fixed constants. No dependencies.
package mbps_pkg;

  localparam int REG_BYTES = 24;
  localparam int INSTR_LEN = 7;
  localparam int DISP_AT   = 3;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_BASE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLVE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_2ND  = 3'd7;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_rva;
    logic [15:0] match_count;
    logic [1:0]  status;
  } out_item_t;

endpackage

FILE: sv/masked_byte_pattern_scanner_top.sv
// Masked byte pattern scanner, top level and only module.
// Depends on mbps_pkg and masked_byte_pattern_scanner_top_defines.svh.
//
//   port group | direction | handshake        | payload
//   in_        | input     | in_valid/ready   | in_item_t  (data_byte, last_byte)
//   out_       | output    | out_valid/ready  | out_item_t (result_rva, match_count, status)
//   cfg_       | input     | cfg_we only      | cfg_index, cfg_wdata (64 bits)
//
// One byte per cycle. A request is held in the input register, where the shifted
// window is compared against the pattern and the section state is updated. The
// result of a last byte goes to the output register when that byte is processed.
// A stalled output blocks only a further last byte; other bytes keep flowing.
// Reset is synchronous and clears the window, the section state, the config registers and the valid bits.
`include "masked_byte_pattern_scanner_top_defines.svh"

module masked_byte_pattern_scanner_top import mbps_pkg::*; #(
  parameter int MAX_PATTERN = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = $clog2(MAX_PATTERN);

  // Configuration registers.
  logic [63:0] pat_low_r, pat_mid_r, pat_high_r;
  logic [REG_BYTES-1:0] care_r;
  logic [4:0]  plen_r;
  logic [31:0] base_r;
  logic        resolve_r;
  logic        pick2_r;

  // Input register and output register.
  logic      s0_v_r;
  in_item_t  s0_r;
  logic      out_valid_r;
  out_item_t out_r;

  // Section state.
  logic [MAX_PATTERN-1:0][7:0] win_r, win_nxt;
  logic [31:0]           pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [31:0]           off1_r, off1_nxt, disp1_r, disp1_nxt;
  logic [31:0]           off2_r, off2_nxt, disp2_r, disp2_nxt;

  logic [REG_BYTES-1:0][7:0] pat;
  logic [LW-1:0]   len_eff;
  logic            hit, match_ok, proc, proc_ok, pick;
  logic [31:0]     moff, mdisp, off_sel, disp_sel, cnt32;
  out_item_t       res;

  assign pat = {pat_high_r, pat_mid_r, pat_low_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '0;
      plen_r     <= 5'd1;
      base_r     <= '0;
      resolve_r  <= 1'b0;
      pick2_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_LOW:   pat_low_r  <= cfg_wdata;
        REG_PAT_MID:   pat_mid_r  <= cfg_wdata;
        REG_PAT_HIGH:  pat_high_r <= cfg_wdata;
        REG_CARE_MASK: care_r     <= cfg_wdata[REG_BYTES-1:0];
        REG_PAT_LEN:   plen_r     <= cfg_wdata[4:0];
        REG_SEC_BASE:  base_r     <= cfg_wdata[31:0];
        REG_RESOLVE:   resolve_r  <= cfg_wdata[0];
        REG_PICK_2ND:  pick2_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one; lengths beyond the window clamp to its depth.
  always_comb begin
    int le;
    le = int'(plen_r);
    if (le == 0) le = 1;
    if (le > MAX_PATTERN) le = MAX_PATTERN;
    len_eff = LW'(le);
  end

  // Handshake: only a last byte needs the output register to be free.
  assign proc_ok  = !s0_r.last_byte || !out_valid_r || out_ready;
  assign proc     = s0_v_r && proc_ok;
  assign in_ready = !s0_v_r || proc_ok;

  assign win_nxt = {win_r[MAX_PATTERN-2:0], s0_r.data_byte};
  assign pos_nxt = (pos_r == '1) ? pos_r : pos_r + 32'd1;

  // Window tap j holds pattern position len-1-j.
  always_comb begin
    int pidx;
    hit = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = int'(len_eff) - 1 - j;
      if (j < int'(len_eff) && pidx < REG_BYTES) begin
        if (care_r[5'(pidx)] && (win_nxt[j] != pat[5'(pidx)])) hit = 1'b0;
      end
    end
  end

  // Little-endian displacement at pattern positions 3 to 6.
  always_comb begin
    int didx;
    mdisp = '0;
    for (int k = 0; k < 4; k++) begin
      didx = int'(len_eff) - 1 - DISP_AT - k;
      mdisp[8*k +: 8] = win_nxt[IW'(didx)];
    end
    if (int'(len_eff) < INSTR_LEN) mdisp = '0;
  end

  assign match_ok = (pos_nxt >= 32'(len_eff)) && hit;
  assign moff     = pos_nxt - 32'(len_eff);

  always_comb begin
    cnt_nxt   = cnt_r;
    off1_nxt  = off1_r;
    disp1_nxt = disp1_r;
    off2_nxt  = off2_r;
    disp2_nxt = disp2_r;
    if (match_ok) begin
      if (cnt_r == '0) begin
        off1_nxt  = moff;
        disp1_nxt = mdisp;
      end else if (cnt_r == COUNT_BITS'(1)) begin
        off2_nxt  = moff;
        disp2_nxt = mdisp;
      end
      if (cnt_r != '1) cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
  end

  // Result of the section, built from the state after this byte.
  always_comb begin
    pick     = pick2_r && (cnt_nxt >= COUNT_BITS'(2));
    off_sel  = pick ? off2_nxt : off1_nxt;
    disp_sel = pick ? disp2_nxt : disp1_nxt;
    cnt32    = 32'(cnt_nxt);
    res.match_count = cnt32[15:0];
    res.result_rva  = '0;
    if (resolve_r && (int'(len_eff) < INSTR_LEN)) begin
      res.status = ST_SHORT;
    end else if (cnt_nxt == '0) begin
      res.status = ST_NO_MATCH;
    end else begin
      res.status = ST_FOUND;
      if (resolve_r) begin
        res.result_rva = base_r + off_sel + 32'(INSTR_LEN) + disp_sel;
      end else begin
        res.result_rva = base_r + off_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ready) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s0_r <= in_data;
  end

  // Section state returns to its reset value after each last byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (proc && s0_r.last_byte)) begin
      win_r   <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
      off1_r  <= '0;
      disp1_r <= '0;
      off2_r  <= '0;
      disp2_r <= '0;
    end else if (proc) begin
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      off1_r  <= off1_nxt;
      disp1_r <= disp1_nxt;
      off2_r  <= off2_nxt;
      disp2_r <= disp2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s0_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s0_r.last_byte) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MBPS_ASSERT_IMPL(a_empty_stage_ready, !s0_v_r, in_ready,
    "input register empty but request refused")
  `MBPS_ASSERT_IMPL(a_result_from_last, $rose(out_valid_r),
    $past(proc && s0_r.last_byte), "result appeared without a last byte")
  `MBPS_ASSERT_NEXT(a_section_cleared, proc && s0_r.last_byte,
    (pos_r == '0) && (cnt_r == '0), "section state not cleared after result")
  `MBPS_ASSERT_IMPL(a_rva_zero_on_miss, out_valid_r && (out_r.status != ST_FOUND),
    out_r.result_rva == '0, "nonzero address without a match")

endmodule

FILE: tb/mbps_checker.sv
`timescale 1ns / 100ps
// Result checker for the masked byte pattern scanner: follows the config port,
// predicts each section result from the accepted requests and compares the outputs.
// Depends on mbps_pkg.
module mbps_checker import mbps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata,
  output int                   error_count,
  output int                   outstanding
);

  // Shadow copy of the configuration registers.
  logic [7:0]  pattern_bytes [REG_BYTES];
  logic [23:0] care_bits;
  logic [4:0]  length_reg;
  logic [31:0] base_reg;
  logic        resolve_reg;
  logic        pick_reg;

  // Section state; recent_bytes[k] is the byte received k requests ago.
  logic [7:0]  recent_bytes [REG_BYTES];
  logic [31:0] byte_pos;
  logic [15:0] hits;
  logic [31:0] first_off;
  logic [31:0] first_disp;
  logic [31:0] second_off;
  logic [31:0] second_disp;

  out_item_t section_results [$];

  task automatic clear_section();
    foreach (recent_bytes[k]) recent_bytes[k] = '0;
    byte_pos    = '0;
    hits        = '0;
    first_off   = '0;
    first_disp  = '0;
    second_off  = '0;
    second_disp = '0;
  endtask

  task automatic scan_byte(input in_item_t item);
    int          len;
    int          k;
    bit          hit;
    logic [31:0] off;
    logic [31:0] disp;
    out_item_t   res;
    len = (length_reg == 0) ? 1 : ((length_reg > REG_BYTES) ? REG_BYTES : int'(length_reg));
    for (k = REG_BYTES - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = item.data_byte;
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;

    // Pattern position i sits len-1-i requests back in the window.
    hit = (byte_pos >= len);
    for (k = 0; k < len; k++) begin
      if (care_bits[k] && recent_bytes[len-1-k] != pattern_bytes[k]) hit = 0;
    end
    if (hit) begin
      off  = byte_pos - len;
      disp = '0;
      if (len >= INSTR_LEN) begin
        disp = {recent_bytes[len-1-DISP_AT-3], recent_bytes[len-1-DISP_AT-2],
                recent_bytes[len-1-DISP_AT-1], recent_bytes[len-1-DISP_AT]};
      end
      if (hits == 0) begin
        first_off  = off;
        first_disp = disp;
      end else if (hits == 1) begin
        second_off  = off;
        second_disp = disp;
      end
      if (hits != 16'hFFFF) hits++;
    end

    if (!item.last_byte) return;

    if (pick_reg && hits >= 2) begin
      off  = second_off;
      disp = second_disp;
    end else begin
      off  = first_off;
      disp = first_disp;
    end
    res.result_rva  = '0;
    res.match_count = hits;
    if (resolve_reg && len < INSTR_LEN) begin
      res.status = ST_SHORT;
    end else if (hits == 0) begin
      res.status = ST_NO_MATCH;
    end else begin
      res.status     = ST_FOUND;
      res.result_rva = base_reg + off;
      // Sign or zero extension of the displacement gives the same 32-bit sum.
      if (resolve_reg) res.result_rva = res.result_rva + 32'(INSTR_LEN) + disp;
    end
    section_results = {section_results, res};
    clear_section();
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    int        k;
    if (!rst_n) begin
      for (k = 0; k < REG_BYTES; k++) pattern_bytes[k] = '0;
      care_bits   = '0;
      length_reg  = 5'd1;
      base_reg    = '0;
      resolve_reg = 1'b0;
      pick_reg    = 1'b0;
      clear_section();
      section_results.delete();
      error_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_LOW, REG_PAT_MID, REG_PAT_HIGH: begin
            for (k = 0; k < 8; k++) pattern_bytes[8*cfg_index + k] = cfg_wdata[8*k +: 8];
          end
          REG_CARE_MASK: care_bits   = cfg_wdata[23:0];
          REG_PAT_LEN:   length_reg  = cfg_wdata[4:0];
          REG_SEC_BASE:  base_reg    = cfg_wdata[31:0];
          REG_RESOLVE:   resolve_reg = cfg_wdata[0];
          REG_PICK_2ND:  pick_reg    = cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (section_results.size() == 0) begin
          $display("%0t: unexpected result, actual rva %h count %0d status %0d", $time,
                   out_data.result_rva, out_data.match_count, out_data.status);
          error_count++;
        end else begin
          want = section_results.pop_front();
          if (out_data.result_rva !== want.result_rva) begin
            $display("%0t: result_rva mismatch, expected %h, actual %h", $time,
                     want.result_rva, out_data.result_rva);
            error_count++;
          end
          if (out_data.match_count !== want.match_count) begin
            $display("%0t: match_count mismatch, expected %0d, actual %0d", $time,
                     want.match_count, out_data.match_count);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_data.status);
            error_count++;
          end
        end
      end

      if (in_valid && in_ready) scan_byte(in_data);
    end
    outstanding = section_results.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the masked byte pattern scanner: clock, reset, requests,
// config writes and result back-pressure. Depends on mbps_pkg and mbps_checker.
module tb_top;
  import mbps_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_wdata;
  int                   error_count;
  int                   outstanding;

  // Mirror of the pattern settings, used to plant matches in the sections.
  logic [7:0]  cur_pattern [REG_BYTES];
  logic [23:0] cur_care;
  int          cur_len;

  logic [7:0]  section_q [$];
  bit          quiet;
  int          hold_cycles;
  int          random_items;

  masked_byte_pattern_scanner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mbps_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: a random stall before each result, plus an occasional long hold-off.
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [63:0] wide_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    int k;
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_PAT_LOW, REG_PAT_MID, REG_PAT_HIGH: begin
        for (k = 0; k < 8; k++) cur_pattern[8*idx + k] = val[8*k +: 8];
      end
      REG_CARE_MASK: cur_care = val[23:0];
      REG_PAT_LEN: begin
        cur_len = (val[4:0] == 0) ? 1 : ((val[4:0] > REG_BYTES) ? REG_BYTES : int'(val[4:0]));
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.data_byte = b;
    in_data.last_byte = last;
    in_valid          = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_section();
    int i;
    for (i = 0; i < section_q.size(); i++) send_byte(section_q[i], i == section_q.size() - 1);
  endtask

  // Stop offering requests and let every expected result come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int         kind;
    int         bad;
    int         i;
    int         n;
    logic [7:0] b;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_PAT_LOW;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    hold_cycles = 0;
    for (i = 0; i < REG_BYTES; i++) cur_pattern[i] = '0;
    cur_care    = '0;
    cur_len     = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one-byte all-wildcard pattern, every byte matches.
    section_q = '{8'h00, 8'hFF, 8'hA5};
    send_section();
    drain();

    // A length of zero acts as one; the second match wraps past the top of the space.
    write_reg(REG_PAT_LOW, 64'hFF);
    write_reg(REG_CARE_MASK, 64'h1);
    write_reg(REG_PAT_LEN, 64'd0);
    write_reg(REG_SEC_BASE, 64'hFFFF_FFFF);
    write_reg(REG_PICK_2ND, 64'd1);
    section_q = '{8'hFF, 8'h00, 8'hFF};
    send_section();
    section_q = '{8'h00};
    send_section();
    drain();

    // Resolve mode with a pattern too short to hold an instruction.
    write_reg(REG_PAT_LEN, 64'd3);
    write_reg(REG_RESOLVE, 64'd1);
    section_q = '{8'hFF, 8'hFF, 8'h12, 8'hFF};
    send_section();
    drain();

    // Resolve a negative displacement, then a section shorter than the pattern.
    write_reg(REG_PAT_LOW, 64'h0000_0000_0005_8B48);
    write_reg(REG_CARE_MASK, 64'h7);
    write_reg(REG_PAT_LEN, 64'd7);
    write_reg(REG_SEC_BASE, 64'h1000);
    write_reg(REG_PICK_2ND, 64'd0);
    section_q = '{8'h48, 8'h8B, 8'h05, 8'hF0, 8'hFF, 8'hFF, 8'hFF};
    send_section();
    section_q = '{8'h48, 8'h8B};
    send_section();
    drain();

    // Oversized length acts as the full window; a single match with pick_second set.
    write_reg(REG_PAT_LOW, '1);
    write_reg(REG_PAT_MID, '1);
    write_reg(REG_PAT_HIGH, '1);
    write_reg(REG_CARE_MASK, 64'hFF_FFFF);
    write_reg(REG_PAT_LEN, 64'd31);
    write_reg(REG_PICK_2ND, 64'd1);
    section_q.delete();
    repeat (REG_BYTES) section_q = {section_q, 8'hFF};
    send_section();
    drain();

    // Long hold-off on the result side while short sections keep coming.
    write_reg(REG_PAT_LEN, 64'd1);
    write_reg(REG_CARE_MASK, 64'd0);
    write_reg(REG_RESOLVE, 64'd0);
    quiet       = 1'b1;
    hold_cycles = 60;
    repeat (12) begin
      section_q = '{8'($urandom), 8'($urandom)};
      send_section();
    end
    quiet = 1'b0;
    drain();

    random_items = 0;
    while (random_items < 680) begin
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(REG_PAT_LOW, wide_value());
      write_reg(REG_PAT_MID, wide_value());
      write_reg(REG_PAT_HIGH, wide_value());
      case ($urandom_range(0, 5))
        0:       write_reg(REG_CARE_MASK, 64'd0);
        1:       write_reg(REG_CARE_MASK, 64'hFF_FFFF);
        2:       write_reg(REG_CARE_MASK, 64'(24'($urandom & $urandom & $urandom)));
        default: write_reg(REG_CARE_MASK, 64'(24'($urandom)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_PAT_LEN, 64'd0);
        1:       write_reg(REG_PAT_LEN, 64'($urandom_range(25, 31)));
        2:       write_reg(REG_PAT_LEN, 64'($urandom_range(13, 24)));
        default: write_reg(REG_PAT_LEN, 64'($urandom_range(1, 12)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_SEC_BASE, 64'd0);
        1:       write_reg(REG_SEC_BASE, 64'(32'hFFFF_FFFF - $urandom_range(0, 64)));
        default: write_reg(REG_SEC_BASE, 64'($urandom));
      endcase
      write_reg(REG_RESOLVE, 64'($urandom_range(0, 1)));
      write_reg(REG_PICK_2ND, 64'($urandom_range(0, 1)));

      repeat ($urandom_range(2, 6)) begin
        // Mostly sections with planted pattern copies; some pure noise, some with
        // one byte of a copy corrupted.
        section_q.delete();
        kind = $urandom_range(0, 7);
        if (kind == 0) begin
          repeat ($urandom_range(1, 30)) section_q = {section_q, 8'($urandom)};
        end else begin
          n = $urandom_range(0, 3);
          repeat (n) begin
            repeat ($urandom_range(0, 6)) section_q = {section_q, 8'($urandom)};
            bad = (kind == 1) ? $urandom_range(0, cur_len - 1) : -1;
            for (i = 0; i < cur_len; i++) begin
              b = cur_care[i] ? cur_pattern[i] : 8'($urandom);
              if (i == bad) b = b ^ (8'h01 << $urandom_range(0, 7));
              section_q = {section_q, b};
            end
          end
          repeat ($urandom_range(0, 4)) section_q = {section_q, 8'($urandom)};
        end
        if (section_q.size() == 0) section_q = {section_q, 8'($urandom)};
        random_items += section_q.size();
        send_section();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
